// File: rtl/dcrb_pkg.sv
// ----------------------------------------------------------------------------
// DMA channel register bank package
// Beat types, register offsets and bit masks shared by the register bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcrb_pkg;

   // number of transfer channels present (1 to 7)
   localparam int CHANNELS = 7;

   // channel index and register nibble widths, fixed by the offset field
   localparam int CH_W  = 3;
   localparam int REG_W = 4;

   localparam logic [CH_W:0]   CHAN_LIMIT   = (CH_W + 1)'(CHANNELS);
   localparam logic [6:0]      CHANNEL_SET  = 7'((1 << CHANNELS) - 1);
   localparam logic [CH_W-1:0] GLOBAL_INDEX = 3'd7;
   localparam logic [CH_W-1:0] LAST_CHANNEL = 3'd6;

   // register offsets within a window
   localparam logic [REG_W-1:0] REG_ADDR  = 4'h0;
   localparam logic [REG_W-1:0] REG_BLOCK = 4'h4;
   localparam logic [REG_W-1:0] REG_CTRL  = 4'h8;
   localparam logic [REG_W-1:0] REG_PRIO  = 4'h0;
   localparam logic [REG_W-1:0] REG_IRQ   = 4'h4;

   // access kinds
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // bit masks
   localparam logic [31:0] CTRL_MASK  = 32'h7177_0703;
   localparam logic [31:0] IRQ_KEEP   = 32'hFF00_7FC0;
   localparam logic [31:0] IRQ_WRITE  = 32'h00FF_803F;
   localparam logic [31:0] IRQ_FLAGS  = 32'hFF00_0000;
   localparam logic [31:0] PRIO_RESET = 32'h0765_4321;
   localparam logic [31:0] UNMAPPED   = 32'hFFFF_FFFF;
   localparam int          CH6_START_BIT = 28;

   typedef struct packed {
      logic        func;
      logic [6:0]  offset;
      logic [31:0] write_data;
      logic [6:0]  pending_requests;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [6:0]  start_channels;
      logic        master_update;
   } rsp_type;

endpackage

// File: rtl/dma_channel_register_bank_core.sv
// A request beat waits in the input register and then in the response register
// before the response beat is valid.
// Throughput: one access per cycle while responses are taken; a stalled
// response holds the response register and a full input register.
// Reset: synchronous, active high; empties both stages, clears the channel
// registers and interrupt word, and loads the priority word with 0x07654321.
// ----------------------------------------------------------------------------
// DMA channel register bank
// Bus register bank of a seven-channel DMA controller with start requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dma_channel_register_bank_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dcrb_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dcrb_pkg::rsp_type rsp_payload
);
   import dcrb_pkg::*;

   // pipeline registers
   logic    s1_valid_ff;
   req_type s1_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   // register bank state
   logic [23:0] chan_addr_ff  [CHANNELS];
   logic [31:0] chan_block_ff [CHANNELS];
   logic [31:0] chan_ctrl_ff  [CHANNELS];
   logic [31:0] prio_ff;
   logic [31:0] irq_ff;
   logic [31:0] irq_in;

   logic             advance;
   logic             fire;
   logic [CH_W-1:0]  ch;
   logic [REG_W-1:0] reg_sel;
   logic             is_write;
   logic             chan_hit;
   logic             global_hit;
   logic [6:0]       req_bits;
   logic [31:0]      wdata;

   // advance both stages when the response slot is free or being taken
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign fire      = s1_valid_ff && advance;

   // decode the held access
   assign ch         = s1_ff.offset[6:4];
   assign reg_sel    = s1_ff.offset[3:0];
   assign is_write   = (s1_ff.func == FUNC_WRITE);
   assign chan_hit   = ({1'b0, ch} < CHAN_LIMIT) && (ch != GLOBAL_INDEX);
   assign global_hit = (ch == GLOBAL_INDEX);
   assign req_bits   = s1_ff.pending_requests & CHANNEL_SET;
   assign wdata      = s1_ff.write_data;

   assign irq_in = ((irq_ff & IRQ_KEEP) | (wdata & IRQ_WRITE)) & ~(wdata & IRQ_FLAGS);

   // build the response beat
   always_comb begin
      rsp_in.read_data      = UNMAPPED;
      rsp_in.start_channels = '0;
      rsp_in.master_update  = 1'b0;
      if (chan_hit) begin
         if (is_write) begin
            if (reg_sel == REG_CTRL) begin
               if (ch == LAST_CHANNEL && wdata[CH6_START_BIT]) begin
                  rsp_in.start_channels[LAST_CHANNEL] = 1'b1;
               end
               if (req_bits[ch]) begin
                  rsp_in.start_channels[ch] = 1'b1;
               end
            end
         end else begin
            unique case (reg_sel)
               REG_ADDR:  rsp_in.read_data = {8'h00, chan_addr_ff[ch]};
               REG_BLOCK: rsp_in.read_data = chan_block_ff[ch];
               REG_CTRL:  rsp_in.read_data = chan_ctrl_ff[ch];
               default:   rsp_in.read_data = UNMAPPED;
            endcase
         end
      end else if (global_hit) begin
         if (is_write) begin
            if (reg_sel == REG_PRIO) begin
               rsp_in.start_channels = req_bits;
            end else if (reg_sel == REG_IRQ) begin
               rsp_in.master_update = 1'b1;
            end
         end else begin
            unique case (reg_sel)
               REG_PRIO: rsp_in.read_data = prio_ff;
               REG_IRQ:  rsp_in.read_data = irq_ff;
               default:  rsp_in.read_data = UNMAPPED;
            endcase
         end
      end
      if (is_write) begin
         rsp_in.read_data = '0;
      end
   end

   // update the bank when the access leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            chan_addr_ff[i]  <= '0;
            chan_block_ff[i] <= '0;
            chan_ctrl_ff[i]  <= '0;
         end
         prio_ff <= PRIO_RESET;
         irq_ff  <= '0;
      end else if (fire && is_write) begin
         if (chan_hit) begin
            unique case (reg_sel)
               REG_ADDR:  chan_addr_ff[ch]  <= wdata[23:0];
               REG_BLOCK: chan_block_ff[ch] <= wdata;
               REG_CTRL:  chan_ctrl_ff[ch]  <= (chan_ctrl_ff[ch] & ~CTRL_MASK)
                                              | (wdata & CTRL_MASK);
               default:   ;
            endcase
         end else if (global_hit) begin
            unique case (reg_sel)
               REG_PRIO: prio_ff <= wdata;
               REG_IRQ:  irq_ff  <= irq_in;
               default:  ;
            endcase
         end
      end
   end

   // advance the valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // hold the payloads
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff <= req_payload;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // both stages empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   // a write beat always returns zero read data
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      (fire && is_write) |=> (rsp_payload.read_data == '0))
      else $error("write returned non-zero read data");

   // a read beat never starts a channel nor flags a master update
   a_read_quiet: assert property (@(posedge clock) disable iff (reset)
      (fire && !is_write) |=> (rsp_payload.start_channels == '0
                              && !rsp_payload.master_update))
      else $error("read raised a start or master update");

   // an interrupt word write starts nothing
   a_master_no_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.master_update) |-> (rsp_payload.start_channels == '0))
      else $error("master update with channel start");

endmodule
